### hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: transaction structs, entry type,
// command and status codes. No dependencies.
package spq_pkg;

  // Field widths of one stored entry
  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;

  // Command codes; the fourth code is ignored by the queue
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [DATA_W-1:0]        item_data;
    logic signed [PRIO_W-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [DATA_W-1:0]        out_data;
    logic signed [PRIO_W-1:0] out_priority;
    logic                     has_entry;
    logic                     last;
  } spq_out_t;

  typedef struct packed {
    logic [DATA_W-1:0]        data;
    logic signed [PRIO_W-1:0] prio;
  } spq_entry_t;

endpackage

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue over one circular entry memory with registered read.
// Depends on spq_pkg for transaction structs and codes.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------
//   command | cmd_valid | cmd_stall | cmd_item (spq_in_t)
//   result  | res_valid | res_stall | res_item (spq_out_t)
//
// One command at a time; cmd_stall is high while a command is in work.
// Insert walks from the tail toward the front, one entry per cycle through
// the single memory read/write port pair. Dump sends one result per stored
// entry; an empty or full command gets a single status reply.
// Reset empties the queue at once (fill, head, state and res_valid only).
// A stalled result register holds its transaction and pauses the walk of a
// remove or dump; the next command is taken while a result still waits.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  spq_in_t  cmd_item,
  output logic     res_valid,
  input  logic     res_stall,
  output spq_out_t res_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_REM,
    S_DUMP,
    S_RESP
  } state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic [AW-1:0] head;
  logic [AW-1:0] widx;
  logic [AW-1:0] dcnt;
  spq_entry_t    new_entry;
  spq_out_t      resp;

  // Entry memory and its registered read port
  spq_entry_t    mem [DEPTH];
  spq_entry_t    rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_log;
  logic          wr_en;
  logic [AW-1:0] wr_log;
  spq_entry_t    wr_entry;

  logic          accept;
  logic          out_free;
  logic          res_load;
  logic          move_up;
  logic          dump_last;

  // Map a logical position (0 = front) onto a memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] lg);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, lg};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign res_load  = out_free && (state == S_REM || state == S_DUMP || state == S_RESP);
  assign move_up   = (rd_q.prio > new_entry.prio);
  assign dump_last = ((CW'(dcnt) + CW'(1)) == fill);

  // Drive the memory ports from the current state
  always_comb begin
    rd_en    = 1'b0;
    rd_log   = '0;
    wr_en    = 1'b0;
    wr_log   = widx;
    wr_entry = new_entry;
    unique case (state)
      S_IDLE: begin
        if (accept && fill != '0) begin
          if (cmd_item.cmd == CMD_INSERT && fill < DEPTH_C) begin
            rd_en  = 1'b1;
            rd_log = AW'(fill - CW'(1));
          end else if (cmd_item.cmd == CMD_REMOVE || cmd_item.cmd == CMD_DUMP) begin
            rd_en  = 1'b1;
            rd_log = '0;
          end
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (move_up) begin
          wr_entry = rd_q;
          if (widx != AW'(1)) begin
            rd_en  = 1'b1;
            rd_log = widx - AW'(2);
          end
        end
      end
      S_INS_PUT: begin
        wr_en = 1'b1;
      end
      S_DUMP: begin
        if (out_free && !dump_last) begin
          rd_en  = 1'b1;
          rd_log = dcnt + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Write and read the entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[phys(head, wr_log)] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[phys(head, rd_log)];
    end
  end

  // Sequence commands, hold the queue pointers and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      head      <= '0;
      res_valid <= 1'b0;
    end else begin
      // Drop a result once it is taken and no new one loads
      if (res_valid && !res_stall && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            new_entry.data   <= cmd_item.item_data;
            new_entry.prio   <= cmd_item.item_priority;
            resp.out_data     <= '0;
            resp.out_priority <= '0;
            resp.has_entry    <= 1'b0;
            resp.last         <= 1'b1;
            priority case (cmd_item.cmd)
              CMD_INSERT: begin
                widx <= fill[AW-1:0];
                if (fill >= DEPTH_C) begin
                  resp.status <= ST_FULL;
                  state       <= S_RESP;
                end else if (fill == '0) begin
                  state <= S_INS_PUT;
                end else begin
                  state <= S_INS_CMP;
                end
              end
              CMD_REMOVE, CMD_DUMP: begin
                dcnt <= '0;
                if (fill == '0) begin
                  resp.status <= ST_EMPTY;
                  state       <= S_RESP;
                end else if (cmd_item.cmd == CMD_REMOVE) begin
                  state <= S_REM;
                end else begin
                  state <= S_DUMP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_CMP: begin
          // Shift the larger entry up one slot, or place the new one
          if (move_up) begin
            widx <= widx - AW'(1);
            if (widx == AW'(1)) begin
              state <= S_INS_PUT;
            end
          end else begin
            fill        <= fill + CW'(1);
            resp.status <= ST_OK;
            state       <= S_RESP;
          end
        end
        S_INS_PUT: begin
          fill        <= fill + CW'(1);
          resp.status <= ST_OK;
          state       <= S_RESP;
        end
        S_REM: begin
          if (out_free) begin
            res_valid             <= 1'b1;
            res_item.status       <= ST_OK;
            res_item.out_data     <= rd_q.data;
            res_item.out_priority <= rd_q.prio;
            res_item.has_entry    <= 1'b1;
            res_item.last         <= 1'b1;
            head                  <= phys(head, AW'(1));
            fill                  <= fill - CW'(1);
            state                 <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            res_valid             <= 1'b1;
            res_item.status       <= ST_OK;
            res_item.out_data     <= rd_q.data;
            res_item.out_priority <= rd_q.prio;
            res_item.has_entry    <= 1'b1;
            res_item.last         <= dump_last;
            dcnt                  <= dcnt + AW'(1);
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_item  <= resp;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### verif/sorted_priority_queue_test.sv
// Self-checking bench for sorted_priority_queue: directed and random commands,
// a sorted-list predictor, random idling on both channels and two long result stalls.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_CMDS  = 355;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 24;
  // The fourth command code; the queue ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    spq_in_t item;
    int      gap;
  } queued_cmd_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  spq_in_t  cmd_item = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  spq_out_t res_item;

  queued_cmd_t cmd_backlog[$];
  queued_cmd_t next_cmd;
  spq_entry_t  sorted_entries[$];
  spq_out_t    replies_due[$];

  int cmds_queued    = 0;
  int cmds_accepted  = 0;
  int replies_seen   = 0;
  int mismatches     = 0;
  int full_drops     = 0;
  int empty_reports  = 0;
  int dumped_entries = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int stall_left     = 0;

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item (cmd_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

  always #6 clk = ~clk;

  // Update the sorted list for one accepted command and queue the replies it owes
  function automatic void apply_queue_cmd(spq_in_t c);
    spq_out_t   r;
    spq_entry_t e;
    int         pos;
    r = '0;
    r.last = 1'b1;
    case (c.cmd)
      CMD_INSERT: begin
        if (sorted_entries.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          pos = 0;
          while (pos < sorted_entries.size() &&
                 $signed(sorted_entries[pos].prio) <= $signed(c.item_priority))
            pos++;
          e.data = c.item_data;
          e.prio = c.item_priority;
          sorted_entries.insert(pos, e);
          r.status = ST_OK;
        end
        replies_due.push_back(r);
      end
      CMD_REMOVE: begin
        if (sorted_entries.size() == 0) begin
          r.status = ST_EMPTY;
          empty_reports++;
        end else begin
          e = sorted_entries.pop_front();
          r.status       = ST_OK;
          r.out_data     = e.data;
          r.out_priority = e.prio;
          r.has_entry    = 1'b1;
        end
        replies_due.push_back(r);
      end
      CMD_DUMP: begin
        if (sorted_entries.size() == 0) begin
          r.status = ST_EMPTY;
          empty_reports++;
          replies_due.push_back(r);
        end else begin
          for (int i = 0; i < sorted_entries.size(); i++) begin
            r.status       = ST_OK;
            r.out_data     = sorted_entries[i].data;
            r.out_priority = sorted_entries[i].prio;
            r.has_entry    = 1'b1;
            r.last         = (i == sorted_entries.size() - 1);
            replies_due.push_back(r);
            dumped_entries++;
          end
        end
      end
      default: ;  // unused code: no reply, list unchanged
    endcase
  endfunction

  // Compare one reply with the oldest one due
  function automatic void check_reply(spq_out_t got);
    spq_out_t want;
    if (replies_due.size() == 0) begin
      $error("unexpected reply: status %0d data %h priority %0d", got.status,
             got.out_data, $signed(got.out_priority));
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.out_data !== want.out_data) begin
      $error("out_data: expected %h, got %h", want.out_data, got.out_data);
      mismatches++;
    end
    if (got.out_priority !== want.out_priority) begin
      $error("out_priority: expected %0d, got %0d", $signed(want.out_priority),
             $signed(got.out_priority));
      mismatches++;
    end
    if (got.has_entry !== want.has_entry) begin
      $error("has_entry: expected %0d, got %0d", want.has_entry, got.has_entry);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endfunction

  // Push one command; every fourth stretch of 30 commands goes without gaps
  task automatic queue_cmd(logic [1:0] c, logic [DATA_W-1:0] d, logic [PRIO_W-1:0] p);
    queued_cmd_t q;
    q.item.cmd           = c;
    q.item.item_data     = d;
    q.item.item_priority = p;
    q.gap = ((cmds_queued / 30) % 4 == 2) ? 0 : $urandom_range(0, 17);
    cmd_backlog.push_back(q);
    cmds_queued++;
  endtask

  // Often small priorities for ties, sometimes the extremes, else anything
  function automatic logic [PRIO_W-1:0] pick_priority();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h8000;
    if (pick == 1) return 16'h7fff;
    if (pick < 6) return PRIO_W'($urandom_range(0, 6) - 3);
    return PRIO_W'($urandom);
  endfunction

  // Command driver: present backlog entries, idle the drawn gap after each transaction
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left = 0;
    end else if (cmd_valid && !cmd_stall) begin
      apply_queue_cmd(cmd_item);
      cmds_accepted++;
      if (cmd_backlog.size() != 0 && cmd_backlog[0].gap == 0) begin
        next_cmd = cmd_backlog.pop_front();
        cmd_item <= next_cmd.item;
      end else begin
        cmd_valid <= 1'b0;
        if (cmd_backlog.size() != 0) gap_left = cmd_backlog[0].gap - 1;
      end
    end else if (!cmd_valid && cmd_backlog.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        next_cmd = cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        cmd_item  <= next_cmd.item;
      end
    end
  end

  // Reply monitor: check each transaction, then stall for a drawn count;
  // hold off for a long stretch twice so the queue backs up on its input
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (res_valid && !res_stall) begin
      check_reply(res_item);
      replies_seen++;
      if (replies_seen == 60 || replies_seen == 400)
        stall_left = LONG_HOLD;
      else if ((replies_seen / 40) % 4 == 3)
        stall_left = 0;
      else
        stall_left = $urandom_range(0, 17);
      res_stall <= (stall_left > 0);
    end else if (res_stall) begin
      stall_left--;
      if (stall_left == 0) res_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int counted;
    int phase_len;
    int ins_pct;
    int roll;

    // Directed: empty queue, unused code, extremes, ties, fill, full, full dump
    queue_cmd(CMD_REMOVE, 32'hffff_ffff, 16'h7fff);
    queue_cmd(CMD_DUMP, 32'h0, 16'h8000);
    queue_cmd(CMD_UNUSED, 32'hdead_beef, 16'h1234);
    queue_cmd(CMD_INSERT, 32'h0000_0000, 16'h8000);
    queue_cmd(CMD_INSERT, 32'hffff_ffff, 16'h7fff);
    queue_cmd(CMD_INSERT, 32'h0000_0001, 16'd5);
    queue_cmd(CMD_INSERT, 32'h0000_0002, 16'd5);
    queue_cmd(CMD_INSERT, 32'h5a5a_5a5a, 16'hffff);
    queue_cmd(CMD_DUMP, 32'h0, 16'h0);
    queue_cmd(CMD_REMOVE, 32'h0, 16'h0);
    repeat (12) queue_cmd(CMD_INSERT, $urandom, pick_priority());
    queue_cmd(CMD_INSERT, 32'ha5a5_a5a5, 16'h0);
    queue_cmd(CMD_DUMP, 32'h0, 16'h0);
    queue_cmd(CMD_REMOVE, 32'h0, 16'h0);

    // Random: phases that lean toward filling, balance, or draining
    counted = 0;
    while (counted < RANDOM_CMDS) begin
      phase_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        default: ins_pct = 20;
      endcase
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          queue_cmd(CMD_UNUSED, $urandom, pick_priority());
        end else begin
          if (roll < 10)
            queue_cmd(CMD_DUMP, $urandom, pick_priority());
          else if (roll < 10 + ins_pct * 90 / 100)
            queue_cmd(CMD_INSERT, $urandom, pick_priority());
          else
            queue_cmd(CMD_REMOVE, $urandom, pick_priority());
          counted++;
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain: every command taken, every reply in, then a quiet margin
    while (cmds_accepted < cmds_queued) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) mismatches++;

    $display("Covered %0d commands and %0d replies in %0d cycles", cmds_accepted,
             replies_seen, cycle_count);
    $display("  %0d inserts dropped when full, %0d empty reports, %0d dumped entries",
             full_drops, empty_reports, dumped_entries);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
